/* rtl/ssc_pkg.sv */
`timescale 1ns / 1ps
package ssc_pkg;

    // Field widths of the stream payloads.
    localparam int COORD_W = 32;
    localparam int RAD_W   = 31;
    localparam int LAYER_W = 16;
    localparam int IN_W    = 288;
    localparam int OUT_W   = 200;

    // Fixed-point formats.
    localparam int COORD_FRAC_BITS = 16;
    localparam int LAYER_BITS      = 16;
    localparam int NORM_FRAC       = 30;

    localparam logic [LAYER_W-1:0] LAYER_MASK = (LAYER_BITS >= LAYER_W) ? {LAYER_W{1'b1}} :
        LAYER_W'((64'd1 << LAYER_BITS) - 64'd1);

    // Derived datapath widths.
    localparam int DELTA_W    = COORD_W + 1;
    localparam int SQ_W       = 2 * DELTA_W;
    localparam int DIST_W     = 2 * COORD_W;
    localparam int RSUM_W     = RAD_W + 1;
    localparam int ROOT_W     = COORD_W + COORD_FRAC_BITS;
    localparam int RADICAND_W = 2 * ROOT_W;
    localparam int QUOT_W     = NORM_FRAC + 1;
    localparam int TT_W       = ROOT_W + 2;
    localparam int TMAG_W     = TT_W - COORD_FRAC_BITS - 1;
    localparam int PROD_W     = TMAG_W + QUOT_W;
    localparam int MAG_W      = PROD_W + 1 - NORM_FRAC;
    localparam int HSUM_W     = MAG_W + 2;

    localparam logic [QUOT_W-1:0] ONE_Q30 = QUOT_W'(1) << NORM_FRAC;

    // Side data that rides along the square-root pipeline.
    typedef struct packed {
        logic [2:0][COORD_W-1:0] a;
        logic [2:0][DELTA_W-1:0] dmag;
        logic [2:0]              dneg;
        logic [RAD_W-1:0]        ra;
        logic [RAD_W-1:0]        rb;
        logic                    collided;
        logic                    degen;
    } sq_side_t;

    // Side data that rides along the divider pipeline.
    typedef struct packed {
        logic [2:0][COORD_W-1:0] a;
        logic [2:0]              dneg;
        logic [TT_W-1:0]         tt;
        logic [ROOT_W-1:0]       s;
        logic                    collided;
        logic                    degen;
    } div_side_t;

endpackage

/* rtl/sphere_sphere_contact.sv */
`timescale 1ns / 1ps
// Channel  Dir  Signals                        Contents
// s        in   s_tvalid s_tready s_tdata      one sphere pair per request
// m        out  m_tvalid m_tready m_tdata      one contact result per request
//
// Each request passes through four setup stages, a 48-stage square root,
// one stage for the contact offset, a 31-stage divider per normal axis and
// three stages for rounding, scaling and the output.
// A new request is taken every cycle while the output is free or being taken.
// The whole pipeline holds when a result waits on m_tready; nothing is dropped.
// Reset clears only the valid bits; the data registers are not reset.
module sphere_sphere_contact (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // a_x, a_y, a_z, a_radius, a_layer, a_still, b_x, b_y, b_z, b_radius,
    // b_layer, b_still from bit 0 up.
    input  logic [ssc_pkg::IN_W-1:0]    s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // collided, degenerate, hit_x, hit_y, hit_z, normal_x, normal_y,
    // normal_z from bit 0 up, then zero padding.
    output logic [ssc_pkg::OUT_W-1:0]   m_tdata
);

    import ssc_pkg::*;

    // Every stage moves together; only a held output stops the pipeline.
    logic adv;
    logic out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic [OUT_W-1:0] out_data_next;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Unpack the request.
    logic [2:0][COORD_W-1:0] in_a;
    logic [2:0][COORD_W-1:0] in_b;
    logic [RAD_W-1:0]        in_ra;
    logic [RAD_W-1:0]        in_rb;
    logic [LAYER_W-1:0]      in_al;
    logic [LAYER_W-1:0]      in_bl;
    logic                    in_as;
    logic                    in_bs;

    assign in_a[0] = s_tdata[31:0];
    assign in_a[1] = s_tdata[63:32];
    assign in_a[2] = s_tdata[95:64];
    assign in_ra   = s_tdata[126:96];
    assign in_al   = s_tdata[142:127];
    assign in_as   = s_tdata[143];
    assign in_b[0] = s_tdata[175:144];
    assign in_b[1] = s_tdata[207:176];
    assign in_b[2] = s_tdata[239:208];
    assign in_rb   = s_tdata[270:240];
    assign in_bl   = s_tdata[286:271];
    assign in_bs   = s_tdata[287];

    // Stage 1: center deltas and the layer and still rules.
    logic                    v1_reg;
    logic [2:0][COORD_W-1:0] a1_reg;
    logic [2:0][DELTA_W-1:0] d1_reg;
    logic [2:0][DELTA_W-1:0] d1_next;
    logic [RAD_W-1:0]        ra1_reg;
    logic [RAD_W-1:0]        rb1_reg;
    logic                    ok1_reg;
    logic                    ok1_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d1_next[i] = {in_b[i][COORD_W-1], in_b[i]} - {in_a[i][COORD_W-1], in_a[i]};
        end
        ok1_next = (|(in_al & in_bl & LAYER_MASK)) && (in_as || in_bs);
    end

    // Stage 2: magnitudes and squares.
    logic                    v2_reg;
    logic [2:0][COORD_W-1:0] a2_reg;
    logic [2:0][DELTA_W-1:0] dmag2_reg;
    logic [2:0][DELTA_W-1:0] dmag2_next;
    logic [2:0]              dneg2_reg;
    logic [2:0][SQ_W-1:0]    sq2_reg;
    logic [2:0][SQ_W-1:0]    sq2_next;
    logic [DIST_W-1:0]       r2_2_reg;
    logic [RSUM_W-1:0]       rsum;
    logic [RAD_W-1:0]        ra2_reg;
    logic [RAD_W-1:0]        rb2_reg;
    logic                    ok2_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dmag2_next[i] = d1_reg[i][DELTA_W-1] ? (DELTA_W'(0) - d1_reg[i]) : d1_reg[i];
            sq2_next[i]   = SQ_W'(dmag2_next[i]) * SQ_W'(dmag2_next[i]);
        end
        rsum = {1'b0, ra1_reg} + {1'b0, rb1_reg};
    end

    // Stage 3: squared distance.
    logic                    v3_reg;
    logic [2:0][COORD_W-1:0] a3_reg;
    logic [2:0][DELTA_W-1:0] dmag3_reg;
    logic [2:0]              dneg3_reg;
    logic [SQ_W-1:0]         dist3_reg;
    logic [DIST_W-1:0]       r2_3_reg;
    logic [RAD_W-1:0]        ra3_reg;
    logic [RAD_W-1:0]        rb3_reg;
    logic                    ok3_reg;

    // Stage 4: contact decision and the radicand for the root.
    logic                    v4_reg;
    sq_side_t                side4_reg;
    sq_side_t                side4_next;
    logic [RADICAND_W-1:0]   rad4_reg;
    logic                    contact3;

    always_comb
    begin
        contact3              = ok3_reg && (dist3_reg <= {2'b00, r2_3_reg});
        side4_next.a          = a3_reg;
        side4_next.dmag       = dmag3_reg;
        side4_next.dneg       = dneg3_reg;
        side4_next.ra         = ra3_reg;
        side4_next.rb         = rb3_reg;
        side4_next.collided   = contact3;
        side4_next.degen      = contact3 && (dist3_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_reg    <= in_a;
            d1_reg    <= d1_next;
            ra1_reg   <= in_ra;
            rb1_reg   <= in_rb;
            ok1_reg   <= ok1_next;

            a2_reg    <= a1_reg;
            dmag2_reg <= dmag2_next;
            for (int i = 0; i < 3; i++)
            begin
                dneg2_reg[i] <= d1_reg[i][DELTA_W-1];
            end
            sq2_reg   <= sq2_next;
            r2_2_reg  <= DIST_W'(rsum) * DIST_W'(rsum);
            ra2_reg   <= ra1_reg;
            rb2_reg   <= rb1_reg;
            ok2_reg   <= ok1_reg;

            a3_reg    <= a2_reg;
            dmag3_reg <= dmag2_reg;
            dneg3_reg <= dneg2_reg;
            dist3_reg <= sq2_reg[0] + sq2_reg[1] + sq2_reg[2];
            r2_3_reg  <= r2_2_reg;
            ra3_reg   <= ra2_reg;
            rb3_reg   <= rb2_reg;
            ok3_reg   <= ok2_reg;

            side4_reg <= side4_next;
            rad4_reg  <= {dist3_reg[DIST_W-1:0], {(2*COORD_FRAC_BITS){1'b0}}};
        end
    end

    // Square root: s is the center distance with extra fraction bits.
    logic [ROOT_W-1:0] root;
    logic              v5_in;
    sq_side_t          side5_in;

    ssc_sqrt #(
        .ROOT_W (ROOT_W)
    ) u_sqrt (
        .clk      (clk),
        .en       (adv),
        .radicand (rad4_reg),
        .root     (root)
    );

    ssc_delay #(
        .W     ($bits(sq_side_t)),
        .DEPTH (ROOT_W)
    ) u_sqrt_side (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v4_reg),
        .in_data   (side4_reg),
        .out_valid (v5_in),
        .out_data  (side5_in)
    );

    // Stage 5: signed contact offset before halving.
    logic                    v5_reg;
    div_side_t               side5_reg;
    div_side_t               side5_next;
    logic [2:0][DELTA_W-1:0] dmag5_reg;
    logic signed [COORD_W-1:0] rdiff;

    always_comb
    begin
        rdiff                = signed'({1'b0, side5_in.ra}) - signed'({1'b0, side5_in.rb});
        side5_next.a         = side5_in.a;
        side5_next.dneg      = side5_in.dneg;
        side5_next.s         = root;
        side5_next.tt        = {{(TT_W-COORD_W-COORD_FRAC_BITS){rdiff[COORD_W-1]}}, rdiff,
                                {COORD_FRAC_BITS{1'b0}}} + {2'b00, root};
        side5_next.collided  = side5_in.collided;
        side5_next.degen     = side5_in.degen;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side5_reg <= side5_next;
            dmag5_reg <= side5_in.dmag;
        end
    end

    // Normal division, one lane per axis.
    logic [2:0][QUOT_W-1:0] quot;
    logic [2:0][ROOT_W-1:0] drem;
    logic                   v6_in;
    div_side_t              side6_in;

    for (genvar g = 0; g < 3; g++)
    begin : g_lane
        ssc_div #(
            .DEN_W  (ROOT_W),
            .QUOT_W (QUOT_W)
        ) u_div (
            .clk  (clk),
            .en   (adv),
            .num  ({dmag5_reg[g], {(NORM_FRAC+COORD_FRAC_BITS){1'b0}}}),
            .den  (side5_reg.s),
            .quot (quot[g]),
            .rem  (drem[g])
        );
    end

    ssc_delay #(
        .W     ($bits(div_side_t)),
        .DEPTH (QUOT_W)
    ) u_div_side (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v5_reg),
        .in_data   (side5_reg),
        .out_valid (v6_in),
        .out_data  (side6_in)
    );

    // Stage 6: round and clamp the normal, halve the offset.
    logic                    v6_reg;
    logic [2:0][COORD_W-1:0] a6_reg;
    logic [2:0]              dneg6_reg;
    logic [2:0][QUOT_W-1:0]  nmag6_reg;
    logic [2:0][QUOT_W-1:0]  nmag6_next;
    logic [TMAG_W-1:0]       tm6_reg;
    logic [TMAG_W-1:0]       tm6_next;
    logic                    tneg6_reg;
    logic                    coll6_reg;
    logic                    degen6_reg;
    logic [TT_W-1:0]         ttmag;
    logic [TT_W-1:0]         ttsum;

    always_comb
    begin
        logic              rup;
        logic [QUOT_W:0]   qr;
        for (int i = 0; i < 3; i++)
        begin
            rup = ({drem[i], 1'b0} >= {1'b0, side6_in.s});
            qr  = {1'b0, quot[i]} + (QUOT_W+1)'(rup);
            if (side6_in.degen)
            begin
                nmag6_next[i] = '0;
            end
            else if (qr > {1'b0, ONE_Q30})
            begin
                nmag6_next[i] = ONE_Q30;
            end
            else
            begin
                nmag6_next[i] = qr[QUOT_W-1:0];
            end
        end
        ttmag    = side6_in.tt[TT_W-1] ? (TT_W'(0) - side6_in.tt) : side6_in.tt;
        ttsum    = ttmag + (TT_W'(1) << COORD_FRAC_BITS);
        tm6_next = ttsum[TT_W-1:COORD_FRAC_BITS+1];
    end

    // Stage 7: scale the normal by the offset.
    logic                    v7_reg;
    logic [2:0][COORD_W-1:0] a7_reg;
    logic [2:0]              dneg7_reg;
    logic [2:0][QUOT_W-1:0]  nmag7_reg;
    logic [2:0][PROD_W-1:0]  prod7_reg;
    logic                    tneg7_reg;
    logic                    coll7_reg;
    logic                    degen7_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a6_reg     <= side6_in.a;
            dneg6_reg  <= side6_in.dneg;
            nmag6_reg  <= nmag6_next;
            tm6_reg    <= tm6_next;
            tneg6_reg  <= side6_in.tt[TT_W-1];
            coll6_reg  <= side6_in.collided;
            degen6_reg <= side6_in.degen;

            a7_reg     <= a6_reg;
            dneg7_reg  <= dneg6_reg;
            nmag7_reg  <= nmag6_reg;
            for (int i = 0; i < 3; i++)
            begin
                prod7_reg[i] <= PROD_W'(tm6_reg) * PROD_W'(nmag6_reg[i]);
            end
            tneg7_reg  <= tneg6_reg;
            coll7_reg  <= coll6_reg;
            degen7_reg <= degen6_reg;

            out_data_reg <= out_data_next;
        end
    end

    // Output stage: add the rounded offset to A's center and saturate.
    always_comb
    begin
        logic [PROD_W:0]          prnd;
        logic [MAG_W-1:0]         mag;
        logic [HSUM_W-1:0]        off;
        logic [HSUM_W-1:0]        hsum;
        logic [2:0][COORD_W-1:0]  hit;
        logic [2:0][COORD_W-1:0]  nrm;
        for (int i = 0; i < 3; i++)
        begin
            prnd = {1'b0, prod7_reg[i]} + ((PROD_W+1)'(1) << (NORM_FRAC - 1));
            mag  = prnd[PROD_W:NORM_FRAC];
            off  = (tneg7_reg ^ dneg7_reg[i]) ? (HSUM_W'(0) - HSUM_W'(mag)) : HSUM_W'(mag);
            hsum = {{(HSUM_W-COORD_W){a7_reg[i][COORD_W-1]}}, a7_reg[i]} + off;
            if (hsum[HSUM_W-1:COORD_W-1] == '0 || hsum[HSUM_W-1:COORD_W-1] == '1)
            begin
                hit[i] = hsum[COORD_W-1:0];
            end
            else if (hsum[HSUM_W-1])
            begin
                hit[i] = {1'b1, {(COORD_W-1){1'b0}}};
            end
            else
            begin
                hit[i] = {1'b0, {(COORD_W-1){1'b1}}};
            end
            nrm[i] = dneg7_reg[i] ? (COORD_W'(0) - COORD_W'(nmag7_reg[i]))
                                  : COORD_W'(nmag7_reg[i]);
        end
        if (coll7_reg)
        begin
            out_data_next = {{(OUT_W-2-6*COORD_W){1'b0}}, nrm[2], nrm[1], nrm[0],
                             hit[2], hit[1], hit[0], degen7_reg, 1'b1};
        end
        else
        begin
            out_data_next = '0;
        end
    end

    // Valid bits of the stages held in this module.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= s_tvalid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v5_in;
            v6_reg        <= v6_in;
            v7_reg        <= v6_reg;
            out_valid_reg <= v7_reg;
        end
    end

endmodule

/* rtl/ssc_delay.sv */
`timescale 1ns / 1ps
module ssc_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         in_valid,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    output logic [W-1:0] out_data
);

    logic         valid_reg [DEPTH];
    logic [W-1:0] data_reg  [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < DEPTH; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg[0] <= in_data;
            for (int i = 1; i < DEPTH; i++)
            begin
                data_reg[i] <= data_reg[i-1];
            end
        end
    end

    assign out_valid = valid_reg[DEPTH-1];
    assign out_data  = data_reg[DEPTH-1];

endmodule

/* rtl/ssc_sqrt.sv */
`timescale 1ns / 1ps
module ssc_sqrt #(
    parameter int ROOT_W = 48
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [2*ROOT_W-1:0]   radicand,
    output logic [ROOT_W-1:0]     root
);

    localparam int RADC_W = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;
    localparam int WIDE_W = ROOT_W + 4;

    // One result bit per stage, restoring digit recurrence.
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_next [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [ROOT_W-1:0] root_next[ROOT_W];
    logic [RADC_W-1:0] rad_reg  [ROOT_W];
    logic [RADC_W-1:0] rad_next [ROOT_W];

    always_comb
    begin
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [RADC_W-1:0] rad_in;
        logic [WIDE_W-1:0] rem2;
        logic [WIDE_W-1:0] trial;
        logic [WIDE_W-1:0] diff;
        for (int i = 0; i < ROOT_W; i++)
        begin
            if (i == 0)
            begin
                rem_in  = '0;
                root_in = '0;
                rad_in  = radicand;
            end
            else
            begin
                rem_in  = rem_reg[i-1];
                root_in = root_reg[i-1];
                rad_in  = rad_reg[i-1];
            end
            rem2  = {rem_in, rad_in[RADC_W-1 -: 2]};
            trial = {2'b00, root_in, 2'b01};
            diff  = rem2 - trial;
            if (rem2 >= trial)
            begin
                rem_next[i]  = diff[REM_W-1:0];
                root_next[i] = {root_in[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[i]  = rem2[REM_W-1:0];
                root_next[i] = {root_in[ROOT_W-2:0], 1'b0};
            end
            rad_next[i] = {rad_in[RADC_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < ROOT_W; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
                rad_reg[i]  <= rad_next[i];
            end
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule

/* rtl/ssc_div.sv */
`timescale 1ns / 1ps
module ssc_div #(
    parameter int DEN_W  = 48,
    parameter int QUOT_W = 31
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic [DEN_W+QUOT_W-1:0]  num,
    input  logic [DEN_W-1:0]         den,
    output logic [QUOT_W-1:0]        quot,
    output logic [DEN_W-1:0]         rem
);

    // The top DEN_W bits of num are below den, so the quotient fits QUOT_W bits.
    logic [DEN_W-1:0]  rem_reg  [QUOT_W];
    logic [DEN_W-1:0]  rem_next [QUOT_W];
    logic [QUOT_W-1:0] low_reg  [QUOT_W];
    logic [QUOT_W-1:0] low_next [QUOT_W];
    logic [DEN_W-1:0]  den_reg  [QUOT_W];
    logic [DEN_W-1:0]  den_next [QUOT_W];
    logic [QUOT_W-1:0] q_reg    [QUOT_W];
    logic [QUOT_W-1:0] q_next   [QUOT_W];

    always_comb
    begin
        logic [DEN_W-1:0]  rem_in;
        logic [QUOT_W-1:0] low_in;
        logic [DEN_W-1:0]  den_in;
        logic [QUOT_W-1:0] q_in;
        logic [DEN_W:0]    r2;
        logic [DEN_W:0]    diff;
        logic              ge;
        for (int i = 0; i < QUOT_W; i++)
        begin
            if (i == 0)
            begin
                rem_in = num[DEN_W+QUOT_W-1 -: DEN_W];
                low_in = num[QUOT_W-1:0];
                den_in = den;
                q_in   = '0;
            end
            else
            begin
                rem_in = rem_reg[i-1];
                low_in = low_reg[i-1];
                den_in = den_reg[i-1];
                q_in   = q_reg[i-1];
            end
            r2   = {rem_in, low_in[QUOT_W-1]};
            diff = r2 - {1'b0, den_in};
            ge   = (r2 >= {1'b0, den_in});
            rem_next[i] = ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
            low_next[i] = {low_in[QUOT_W-2:0], 1'b0};
            den_next[i] = den_in;
            q_next[i]   = {q_in[QUOT_W-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < QUOT_W; i++)
            begin
                rem_reg[i] <= rem_next[i];
                low_reg[i] <= low_next[i];
                den_reg[i] <= den_next[i];
                q_reg[i]   <= q_next[i];
            end
        end
    end

    assign quot = q_reg[QUOT_W-1];
    assign rem  = rem_reg[QUOT_W-1];

endmodule
